/* sv/shts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted hash table search package
// Shared widths, operation codes and the queued work item type.
// ----------------------------------------------------------------------------
package shts_pkg;

  localparam int IDX_W = 10;
  localparam int KEY_W = 32;
  localparam int CNT_W = 11;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] index;
    logic [KEY_W-1:0] data;
  } work_item_t;

endpackage

/* sv/shts_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted hash table search front end
// Accepts command transfers, tags them as table writes or searches and
// holds them in a two-entry queue until the search engine takes them.
// ----------------------------------------------------------------------------
module shts_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_func,
  input  logic [shts_pkg::IDX_W-1:0]          in_entry_index,
  input  logic [shts_pkg::KEY_W-1:0]          in_entry_value,
  input  logic [shts_pkg::KEY_W-1:0]          in_search_key,
  output logic                                q_valid,
  input  logic                                q_ready,
  output shts_pkg::work_item_t                q_item
);

  localparam int QDEPTH = 2;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  shts_pkg::work_item_t q_r [QDEPTH];
  logic [PTR_W-1:0]     wr_ptr_r;
  logic [PTR_W-1:0]     rd_ptr_r;
  logic [QCNT_W-1:0]    cnt_r;
  logic [QCNT_W-1:0]    cnt_nxt;
  logic                 push;
  logic                 pop;
  shts_pkg::work_item_t new_item;

  assign busy    = (cnt_r == QCNT_W'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = q_r[rd_ptr_r];
  assign push    = start && !busy;
  assign pop     = q_valid && q_ready;

  always_comb begin
    new_item.op    = shts_pkg::op_t'(in_func);
    new_item.index = in_entry_index;
    new_item.data  = (new_item.op == shts_pkg::OP_SEARCH) ? in_search_key : in_entry_value;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

/* sv/shts_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted hash table search engine
// Owns the hash table memory, performs table writes and runs the binary
// search, one table read per cycle, emitting one result per search.
// ----------------------------------------------------------------------------
module shts_back #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  shts_pkg::work_item_t        q_item,
  input  logic [shts_pkg::CNT_W-1:0]  entry_count,
  output logic                        out_valid,
  output logic                        out_found,
  output logic [shts_pkg::IDX_W-1:0]  out_match_index
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_PROBE
  } state_t;

  state_t                     state_r;
  logic [shts_pkg::KEY_W-1:0] mem [TABLE_DEPTH];
  logic [shts_pkg::KEY_W-1:0] rd_data_r;
  logic [shts_pkg::KEY_W-1:0] key_r;
  logic [CW-1:0]              lo_r;
  logic [CW-1:0]              hi_r;
  logic [CW-1:0]              mid_r;

  logic                       pop;
  logic [CW-1:0]              hi0;
  logic [CW-1:0]              mid0;
  logic                       probe_eq;
  logic                       probe_gt;
  logic [CW-1:0]              lo_nxt;
  logic [CW-1:0]              hi_nxt;
  logic [CW-1:0]              mid_nxt;
  logic                       more;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;

  assign q_ready = (state_r == S_IDLE);
  assign pop     = q_valid && q_ready;

  always_comb begin
    hi0 = (32'(entry_count) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(entry_count);
    mid0 = hi0 >> 1;
    probe_eq = (rd_data_r == key_r);
    probe_gt = (rd_data_r > key_r);
    lo_nxt = probe_gt ? lo_r : mid_r + CW'(1);
    hi_nxt = probe_gt ? mid_r : hi_r;
    mid_nxt = lo_nxt + ((hi_nxt - lo_nxt) >> 1);
    more = (lo_nxt < hi_nxt);
    wr_en = pop && (q_item.op == shts_pkg::OP_WRITE)
            && (32'(q_item.index) < 32'(TABLE_DEPTH));
    wr_addr = AW'(q_item.index);
    rd_en = 1'b0;
    rd_addr = mid0[AW-1:0];
    if (pop && (q_item.op == shts_pkg::OP_SEARCH) && (hi0 != '0)) begin
      rd_en = 1'b1;
    end else if ((state_r == S_PROBE) && !probe_eq && more) begin
      rd_en   = 1'b1;
      rd_addr = mid_nxt[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= q_item.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (pop && (q_item.op == shts_pkg::OP_SEARCH)) begin
            key_r <= q_item.data;
            lo_r  <= '0;
            hi_r  <= hi0;
            mid_r <= mid0;
            if (hi0 == '0) begin
              out_valid       <= 1'b1;
              out_found       <= 1'b0;
              out_match_index <= '0;
            end else begin
              state_r <= S_PROBE;
            end
          end
        end
        S_PROBE: begin
          if (probe_eq) begin
            out_valid       <= 1'b1;
            out_found       <= 1'b1;
            out_match_index <= shts_pkg::IDX_W'(mid_r);
            state_r         <= S_IDLE;
          end else if (more) begin
            lo_r  <= lo_nxt;
            hi_r  <= hi_nxt;
            mid_r <= mid_nxt;
          end else begin
            out_valid       <= 1'b1;
            out_found       <= 1'b0;
            out_match_index <= '0;
            state_r         <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/sorted_hash_table_search_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted hash table search unit
// Binary search over a stored, ascending table of 32-bit name hashes.
//
// Usage: a command transfer happens at a clock edge with start high and busy
// low. in_func low stores in_entry_value at in_entry_index and gives no
// result; in_func high searches for in_search_key among the first
// entry_count entries, at most TABLE_DEPTH. Each search gives one result:
// out_valid is high for exactly one cycle with out_found and out_match_index,
// and the receiver cannot stall it. Commands wait in a two-entry queue; busy
// is high while it is full. A table write is done as the engine takes it from
// the queue. A search is started and then makes one probe after another, each
// probe being one read of the table memory. When entry_count is zero, a search
// reads no entry and gives a not-found result. entry_count is written over
// the APB port at address 0 (only paddr[2] is decoded); the user must write it
// only while the unit is idle, which the block itself does not enforce. Reset
// empties the queue, clears entry_count and leaves the table contents
// undefined.
// ----------------------------------------------------------------------------
module sorted_hash_table_search_unit #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_func,
  input  logic [shts_pkg::IDX_W-1:0]  in_entry_index,
  input  logic [shts_pkg::KEY_W-1:0]  in_entry_value,
  input  logic [shts_pkg::KEY_W-1:0]  in_search_key,
  output logic                        out_valid,
  output logic                        out_found,
  output logic [shts_pkg::IDX_W-1:0]  out_match_index,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [shts_pkg::CNT_W-1:0] entry_count_r;
  logic                       q_valid;
  logic                       q_ready;
  shts_pkg::work_item_t       q_item;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(entry_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      entry_count_r <= pwdata[shts_pkg::CNT_W-1:0];
    end
  end

  shts_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .in_search_key  (in_search_key),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_item         (q_item)
  );

  shts_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_ready         (q_ready),
    .q_item          (q_item),
    .entry_count     (entry_count_r),
    .out_valid       (out_valid),
    .out_found       (out_found),
    .out_match_index (out_match_index)
  );

endmodule

/* bench/sorted_hash_table_search_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted hash table search unit testbench
// Fills table prefixes with sorted, duplicated or scrambled hashes, sets
// entry_count over APB and sends lookups and table writes under random sender
// idling. A shadow copy of the table follows the same halving probe path to
// predict each lookup result that has no fixed expectation, and every result
// transfer is checked against the oldest expected result.
// ----------------------------------------------------------------------------
module sorted_hash_table_search_unit_tb;

  localparam int DEPTH = 1024;
  localparam int HALF = DEPTH / 2;
  localparam logic [2:0] ADDR_ENTRY_COUNT = 3'd0;
  localparam int MAX_REPORTS = 10;
  localparam int SETTLE_CYCLES = 40;
  localparam int NUM_DIRECTED = 20;

  typedef struct packed {
    logic                       found;
    logic [shts_pkg::IDX_W-1:0] index;
  } lookup_t;

  typedef enum {ROW_CMD, ROW_CFG} row_kind_t;
  typedef enum {FILL_SORTED, FILL_DUPLICATES, FILL_SCRAMBLED} fill_kind_t;

  typedef struct {
    row_kind_t                  kind;
    shts_pkg::op_t              op;
    logic [shts_pkg::IDX_W-1:0] index;
    logic [shts_pkg::KEY_W-1:0] value;
    logic [shts_pkg::KEY_W-1:0] key;
    bit                         typed;
    bit                         want_found;
    logic [shts_pkg::IDX_W-1:0] want_index;
  } stim_row_t;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic                       in_func;
  logic [shts_pkg::IDX_W-1:0] in_entry_index;
  logic [shts_pkg::KEY_W-1:0] in_entry_value;
  logic [shts_pkg::KEY_W-1:0] in_search_key;
  logic                       out_valid;
  logic                       out_found;
  logic [shts_pkg::IDX_W-1:0] out_match_index;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [2:0]                 paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;

  logic [shts_pkg::KEY_W-1:0] shadow_hashes [DEPTH];
  logic [shts_pkg::CNT_W-1:0] shadow_count;
  lookup_t                    expected_lookups [$];
  int                         mismatches;
  int                         sender_idle_pct;
  int                         commands_sent;
  stim_row_t                  directed [NUM_DIRECTED];

  sorted_hash_table_search_unit #(
    .TABLE_DEPTH(DEPTH)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .in_search_key  (in_search_key),
    .out_valid      (out_valid),
    .out_found      (out_found),
    .out_match_index(out_match_index),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic lookup_t probe_table(logic [shts_pkg::KEY_W-1:0] key);
    int      lo;
    int      hi;
    int      mid;
    lookup_t hit;
    hit = '0;
    lo = 0;
    hi = (shadow_count > DEPTH) ? DEPTH : int'(shadow_count);
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (shadow_hashes[mid] == key) begin
        hit.found = 1'b1;
        hit.index = mid[shts_pkg::IDX_W-1:0];
        return hit;
      end
      if (shadow_hashes[mid] > key) hi = mid;
      else lo = mid + 1;
    end
    return hit;
  endfunction

  function automatic logic [shts_pkg::KEY_W-1:0] pick_key(int n);
    int                         roll;
    logic [shts_pkg::KEY_W-1:0] stored;
    roll = $urandom_range(99);
    stored = (n > 0) ? shadow_hashes[$urandom_range(n - 1)] : $urandom;
    if (roll < 60) return stored;
    if (roll < 75) return $urandom_range(1) ? stored + 32'd1 : stored - 32'd1;
    if (roll < 90) return $urandom;
    if (roll < 95) return '0;
    return '1;
  endfunction

  task automatic flag_error(string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t: %s", $realtime, what);
  endtask

  always @(posedge clk) begin : check_results
    lookup_t want;
    if (rst_n && out_valid) begin
      if (expected_lookups.size() == 0) begin
        flag_error($sformatf("result with nothing expected: found=%0b index=%0d",
                             out_found, out_match_index));
      end else begin
        want = expected_lookups.pop_front();
        if (out_found !== want.found || out_match_index !== want.index) begin
          flag_error($sformatf("lookup: expected found=%0b index=%0d, got found=%0b index=%0d",
                               want.found, want.index, out_found, out_match_index));
        end
      end
    end
  end

  task automatic issue_command(shts_pkg::op_t op, logic [shts_pkg::IDX_W-1:0] index,
                               logic [shts_pkg::KEY_W-1:0] value,
                               logic [shts_pkg::KEY_W-1:0] key, bit typed = 1'b0,
                               lookup_t want = '0);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_func = op;
    in_entry_index = index;
    in_entry_value = value;
    in_search_key = key;
    do @(posedge clk); while (busy);
    commands_sent++;
    if (op == shts_pkg::OP_WRITE) shadow_hashes[index] = value;
    else expected_lookups.push_back(typed ? want : probe_table(key));
  endtask

  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_entry_count(logic [31:0] value);
    settle();
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = ADDR_ENTRY_COUNT;
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    shadow_count = value[shts_pkg::CNT_W-1:0];
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== 32'(shadow_count)) begin
      flag_error($sformatf("entry_count readback: expected %0d, got %0d",
                           shadow_count, prdata));
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic fill_prefix(int n, fill_kind_t kind);
    logic [shts_pkg::KEY_W-1:0] vals [$];
    int                         order [$];
    int                         i;
    int                         j;
    int                         tmp;
    for (i = 0; i < n; i++) begin
      case (kind)
        FILL_DUPLICATES: vals.push_back(32'($urandom_range(15)) << 28);
        FILL_SORTED: begin
          if ($urandom_range(99) < 5) vals.push_back($urandom_range(1) ? '1 : '0);
          else vals.push_back($urandom);
        end
        default: vals.push_back($urandom);
      endcase
      order.push_back(i);
    end
    if (kind != FILL_SCRAMBLED) vals.sort();
    for (i = n - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    foreach (order[k]) begin
      issue_command(shts_pkg::OP_WRITE, order[k][shts_pkg::IDX_W-1:0], vals[order[k]],
                    $urandom);
    end
  endtask

  task automatic run_searches(int count, int n, bit with_writes = 1'b1);
    int i;
    for (i = 0; i < count; i++) begin
      if (with_writes && $urandom_range(9) == 0) begin
        if (n > 0 && $urandom_range(1)) begin
          issue_command(shts_pkg::OP_WRITE, shts_pkg::IDX_W'($urandom_range(n - 1)),
                        $urandom, $urandom);
        end else begin
          issue_command(shts_pkg::OP_WRITE, shts_pkg::IDX_W'($urandom_range(DEPTH - 1)),
                        $urandom, $urandom);
        end
      end
      issue_command(shts_pkg::OP_SEARCH, shts_pkg::IDX_W'($urandom), $urandom, pick_key(n));
    end
  endtask

  task automatic run_phase();
    int n;
    n = ($urandom_range(7) == 0) ? $urandom_range(49, 160) : $urandom_range(1, 48);
    fill_prefix(n, fill_kind_t'($urandom_range(2)));
    write_entry_count(n);
    run_searches($urandom_range(15, 35), n);
  endtask

  initial begin
    directed = '{
      '{ROW_CMD, shts_pkg::OP_SEARCH, 10'd0, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 10'd0},
      '{ROW_CMD, shts_pkg::OP_SEARCH, 10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 10'd0},
      '{ROW_CMD, shts_pkg::OP_WRITE, 10'd0, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 10'd0},
      '{ROW_CMD, shts_pkg::OP_WRITE, 10'd1, 32'h0000_0005, 32'h0000_0000, 1'b0, 1'b0, 10'd0},
      '{ROW_CMD, shts_pkg::OP_WRITE, 10'd2, 32'h0000_0005, 32'h0000_0000, 1'b0, 1'b0, 10'd0},
      '{ROW_CMD, shts_pkg::OP_WRITE, 10'd3, 32'h0000_0005, 32'h0000_0000, 1'b0, 1'b0, 10'd0},
      '{ROW_CMD, shts_pkg::OP_WRITE, 10'd4, 32'h0000_0064, 32'h0000_0000, 1'b0, 1'b0, 10'd0},
      '{ROW_CMD, shts_pkg::OP_WRITE, 10'd5, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 10'd0},
      '{ROW_CMD, shts_pkg::OP_WRITE, 10'd6, 32'hFFFF_FFFE, 32'h0000_0000, 1'b0, 1'b0, 10'd0},
      '{ROW_CMD, shts_pkg::OP_WRITE, 10'd7, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 10'd0},
      '{ROW_CFG, shts_pkg::OP_WRITE, 10'd0, 32'd8, 32'h0000_0000, 1'b0, 1'b0, 10'd0},
      '{ROW_CMD, shts_pkg::OP_SEARCH, 10'd0, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 10'd0},
      '{ROW_CMD, shts_pkg::OP_SEARCH, 10'd0, 32'h0000_0000, 32'h0000_0005, 1'b0, 1'b0, 10'd0},
      '{ROW_CMD, shts_pkg::OP_SEARCH, 10'd0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 10'd0},
      '{ROW_CMD, shts_pkg::OP_SEARCH, 10'd0, 32'h0000_0000, 32'h0000_0006, 1'b0, 1'b0, 10'd0},
      '{ROW_CMD, shts_pkg::OP_SEARCH, 10'd0, 32'h0000_0000, 32'h8000_0000, 1'b0, 1'b0, 10'd0},
      '{ROW_CMD, shts_pkg::OP_WRITE, 10'd1023, 32'hA5A5_5A5A, 32'h0000_0000, 1'b0, 1'b0, 10'd0},
      '{ROW_CFG, shts_pkg::OP_WRITE, 10'd0, 32'd1, 32'h0000_0000, 1'b0, 1'b0, 10'd0},
      '{ROW_CMD, shts_pkg::OP_SEARCH, 10'd0, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 10'd0},
      '{ROW_CMD, shts_pkg::OP_SEARCH, 10'd0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 10'd0}
    };
    rst_n = 1'b0;
    start = 1'b0;
    in_func = 1'b0;
    in_entry_index = '0;
    in_entry_value = '0;
    in_search_key = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    shadow_count = '0;
    mismatches = 0;
    commands_sent = 0;
    sender_idle_pct = 32;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[r]) begin
      if (directed[r].kind == ROW_CFG) begin
        write_entry_count(directed[r].value);
      end else begin
        issue_command(directed[r].op, directed[r].index, directed[r].value, directed[r].key,
                      directed[r].typed, {directed[r].want_found, directed[r].want_index});
      end
    end

    while (commands_sent < 170) run_phase();
    sender_idle_pct = 74;
    while (commands_sent < 340) run_phase();
    sender_idle_pct = 0;

    // The lower half is sorted and the middle entry holds the largest hash, so a
    // full or oversized entry_count keeps every probe path inside written entries.
    fill_prefix(HALF, FILL_SORTED);
    issue_command(shts_pkg::OP_WRITE, shts_pkg::IDX_W'(HALF), '1, $urandom);
    write_entry_count(DEPTH);
    run_searches(40, HALF + 1, 1'b0);
    write_entry_count(2047);
    run_searches(20, HALF + 1, 1'b0);
    write_entry_count(0);
    run_searches(3, 0);

    settle();
    if (mismatches == 0 && expected_lookups.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
